FILE: sv/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg - shared definitions for the selective-repeat receiver
// Field widths, parameter defaults and result kind codes.
// ----------------------------------------------------------------------------
package srr_pkg;

   // fixed field widths of the channels
   localparam int SEQ_W     = 3;
   localparam int PAYLOAD_W = 64;

   // defaults for the top level parameters
   localparam int WINDOW_SIZE_DEF  = 4;
   localparam int SEQ_SPACE_DEF    = 8;
   localparam int PAYLOAD_BITS_DEF = 64;

   // result kind codes
   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

endpackage

FILE: sv/srr_channels.sv
// ----------------------------------------------------------------------------
// srr_channels - valid/ready channels of the selective-repeat receiver
// Packet channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface srr_req_if;
   logic                           valid;
   logic                           ready;
   logic                           checksum_ok;
   logic [srr_pkg::SEQ_W-1:0]      seq_number;
   logic [srr_pkg::PAYLOAD_W-1:0]  payload_word;

   modport source (output valid, checksum_ok, seq_number, payload_word, input ready);
   modport sink   (input valid, checksum_ok, seq_number, payload_word, output ready);
endinterface

interface srr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           result_kind;
   logic [srr_pkg::SEQ_W-1:0]      ack_number;
   logic [srr_pkg::PAYLOAD_W-1:0]  delivered_payload;
   logic                           last_of_run;

   modport source (output valid, result_kind, ack_number, delivered_payload, last_of_run,
                   input ready);
   modport sink   (input valid, result_kind, ack_number, delivered_payload, last_of_run,
                   output ready);
endinterface

FILE: sv/srr_ram.sv
// ----------------------------------------------------------------------------
// srr_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/srr_mod_add.sv
// ----------------------------------------------------------------------------
// srr_mod_add - shared modular adder
// Returns (a + b) mod m for operands below m, by one compare and subtract.
// ----------------------------------------------------------------------------
module srr_mod_add #(
   parameter int SUM_W = 8
) (
   input  logic [SUM_W-1:0] a,
   input  logic [SUM_W-1:0] b,
   input  logic [SUM_W-1:0] m,
   output logic [SUM_W-1:0] y
);

   logic [SUM_W-1:0] sum;

   // add, then fold back once into the range of the modulus
   always_comb begin
      sum = a + b;
      y   = (sum >= m) ? (sum - m) : sum;
   end

endmodule

FILE: sv/selective_repeat_receiver.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver - selective-repeat ARQ receive window
// Acknowledges good packets, buffers in-window payloads and delivers them
// upward in sequence order.
// ----------------------------------------------------------------------------
// A packet is taken only while the sequencer is idle. A packet with a bad
// checksum is dropped at once and the block stays ready. A good packet
// passes through S_OFF, S_IDX and S_ACK, then through S_DLV and S_ADV for
// each of the D in-order payloads it releases (0 to WINDOW_SIZE), and the
// result side can stall S_ACK and S_DLV. These steps follow from the one modular
// adder that the sequencer uses in turn for the window offset, the slot
// index, the head pointer step and the window base step, and from the
// registered read of the payload RAM. One result leaves per item: first the
// ACK, then each delivery, with last_of_run on the final one.
// ----------------------------------------------------------------------------
module selective_repeat_receiver #(
   parameter int WINDOW_SIZE  = srr_pkg::WINDOW_SIZE_DEF,
   parameter int SEQ_SPACE    = srr_pkg::SEQ_SPACE_DEF,
   parameter int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   srr_req_if.sink   req,
   srr_rsp_if.source rsp
);

   localparam int BASE_W = $clog2(SEQ_SPACE);
   localparam int PTR_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int MAXV   = (SEQ_SPACE > WINDOW_SIZE) ? SEQ_SPACE : WINDOW_SIZE;
   localparam int SUM_W  = $clog2(2 * MAXV) + 1;
   localparam logic [SUM_W-1:0] SEQ_SPACE_W = SUM_W'(SEQ_SPACE);
   localparam logic [SUM_W-1:0] WINDOW_W    = SUM_W'(WINDOW_SIZE);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_OFF  = 6'b000010,
      S_IDX  = 6'b000100,
      S_ACK  = 6'b001000,
      S_DLV  = 6'b010000,
      S_ADV  = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   logic [BASE_W-1:0]             base_ff, base_in;
   logic [PTR_W-1:0]              ptr_ff, ptr_in;
   logic [WINDOW_SIZE-1:0]        recv_ff, recv_in;
   logic [BASE_W-1:0]             off_ff, off_in;
   logic                          more_ff, more_in;
   logic [srr_pkg::SEQ_W-1:0]     seq_raw_ff, seq_raw_in;
   logic [BASE_W-1:0]             seq_mod_ff, seq_mod_in;
   logic [PAYLOAD_BITS-1:0]       pay_ff, pay_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          kind_ff, kind_in;
   logic [srr_pkg::SEQ_W-1:0]     ack_ff, ack_in;
   logic [srr_pkg::PAYLOAD_W-1:0] data_ff, data_in;
   logic                          last_ff, last_in;

   logic [SUM_W-1:0]              unit_a, unit_b, unit_m, unit_y;
   logic [PTR_W-1:0]              unit_ptr;
   logic                          in_window;
   logic                          out_free;
   logic                          ram_wr_en;
   logic [PAYLOAD_BITS-1:0]       ram_rd_data;
   logic                          dlv_last;

   // reduce a received sequence number into the sequence space by table
   function automatic logic [BASE_W-1:0] seq_reduce(input logic [srr_pkg::SEQ_W-1:0] seq);
      logic [BASE_W-1:0] r;
      r = '0;
      for (int v = 0; v < (1 << srr_pkg::SEQ_W); v++) begin
         if (seq == srr_pkg::SEQ_W'(v)) begin
            r = BASE_W'(v % SEQ_SPACE);
         end
      end
      return r;
   endfunction

   // shared modular adder
   srr_mod_add #(.SUM_W(SUM_W)) u_mod_add (
      .a (unit_a),
      .b (unit_b),
      .m (unit_m),
      .y (unit_y)
   );

   // payload slots, addressed by physical slot index
   srr_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(WINDOW_SIZE)) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (unit_ptr),
      .wr_data (pay_ff),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign unit_ptr  = unit_y[PTR_W-1:0];
   assign in_window = SUM_W'(off_ff) < WINDOW_W;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign ram_wr_en = (state_ff == S_IDX) && in_window && !recv_ff[unit_ptr];
   assign dlv_last  = (unit_ptr == ptr_ff) || !recv_ff[unit_ptr];

   assign req.ready             = (state_ff == S_IDLE);
   assign rsp.valid             = rsp_valid_ff;
   assign rsp.result_kind       = kind_ff;
   assign rsp.ack_number        = ack_ff;
   assign rsp.delivered_payload = data_ff;
   assign rsp.last_of_run       = last_ff;

   // select the operands of the shared adder for the current step
   always_comb begin
      unit_a = '0;
      unit_b = '0;
      unit_m = SEQ_SPACE_W;
      unique case (state_ff)
         S_OFF: begin
            unit_a = SUM_W'(seq_mod_ff);
            unit_b = SEQ_SPACE_W - SUM_W'(base_ff);
            unit_m = SEQ_SPACE_W;
         end
         S_IDX: begin
            unit_a = SUM_W'(ptr_ff);
            unit_b = in_window ? SUM_W'(off_ff) : '0;
            unit_m = WINDOW_W;
         end
         S_DLV: begin
            unit_a = SUM_W'(ptr_ff);
            unit_b = SUM_W'(1);
            unit_m = WINDOW_W;
         end
         S_ADV: begin
            unit_a = SUM_W'(base_ff);
            unit_b = SUM_W'(1);
            unit_m = SEQ_SPACE_W;
         end
         S_IDLE, S_ACK: begin
            unit_a = '0;
         end
         default: begin
            unit_a = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      ptr_in       = ptr_ff;
      recv_in      = recv_ff;
      off_in       = off_ff;
      more_in      = more_ff;
      seq_raw_in   = seq_raw_ff;
      seq_mod_in   = seq_mod_ff;
      pay_in       = pay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      kind_in      = kind_ff;
      ack_in       = ack_ff;
      data_in      = data_ff;
      last_in      = last_ff;

      unique case (state_ff)
         // take a packet; drop it when the checksum failed
         S_IDLE: begin
            if (req.valid && req.checksum_ok) begin
               seq_raw_in = req.seq_number;
               seq_mod_in = seq_reduce(req.seq_number);
               pay_in     = req.payload_word[PAYLOAD_BITS-1:0];
               state_in   = S_OFF;
            end
         end
         // window offset of the sequence number
         S_OFF: begin
            off_in   = unit_y[BASE_W-1:0];
            state_in = S_IDX;
         end
         // mark the slot; the RAM write runs alongside
         S_IDX: begin
            if (in_window) begin
               recv_in[unit_ptr] = 1'b1;
            end
            state_in = S_ACK;
         end
         // issue the ACK
         S_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = srr_pkg::KIND_ACK;
               ack_in       = seq_raw_ff;
               data_in      = '0;
               last_in      = !recv_ff[ptr_ff];
               state_in     = recv_ff[ptr_ff] ? S_DLV : S_IDLE;
            end
         end
         // deliver the head slot, clear it and step the head pointer
         S_DLV: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               kind_in         = srr_pkg::KIND_DELIVER;
               ack_in          = '0;
               data_in         = srr_pkg::PAYLOAD_W'(ram_rd_data);
               last_in         = dlv_last;
               recv_in[ptr_ff] = 1'b0;
               ptr_in          = unit_ptr;
               more_in         = !dlv_last;
               state_in        = S_ADV;
            end
         end
         // advance the window base
         S_ADV: begin
            base_in  = unit_y[BASE_W-1:0];
            state_in = more_ff ? S_DLV : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         ptr_ff       <= '0;
         recv_ff      <= '0;
         more_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         ptr_ff       <= ptr_in;
         recv_ff      <= recv_in;
         more_ff      <= more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      off_ff     <= off_in;
      seq_raw_ff <= seq_raw_in;
      seq_mod_ff <= seq_mod_in;
      pay_ff     <= pay_in;
      kind_ff    <= kind_in;
      ack_ff     <= ack_in;
      data_ff    <= data_in;
      last_ff    <= last_in;
   end

`ifndef SYNTHESIS
   // a delivery is only issued from a marked head slot
   a_dlv_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DLV) && out_free |-> recv_ff[ptr_ff])
      else $error("delivery from an unmarked slot");

   // a delivered slot is cleared in the next cycle
   a_dlv_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DLV) && out_free |=> !recv_ff[$past(ptr_ff)])
      else $error("delivered slot still marked");

   // an ACK that ends the run returns the sequencer to idle
   a_ack_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACK) && out_free && !recv_ff[ptr_ff] |=> (state_ff == S_IDLE))
      else $error("sequencer busy after final ACK");

   // every issued result sets the output valid
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_ACK) || (state_ff == S_DLV)) && out_free |=> rsp_valid_ff)
      else $error("result loaded without valid");

   // one-hot sequencer state
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");
`endif

endmodule

FILE: tb/sv/selective_repeat_receiver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// selective_repeat_receiver_test - self-checking bench for the SR receiver
// Runs a stimulus table of packets and then phases of random packets with
// sender gaps and result-side stalls. A model of the receive window predicts
// the ACK and delivery items of each accepted packet. Each result item is
// checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_test;

   localparam int WINDOW_SIZE  = srr_pkg::WINDOW_SIZE_DEF;
   localparam int SEQ_SPACE    = srr_pkg::SEQ_SPACE_DEF;
   localparam int PAYLOAD_BITS = srr_pkg::PAYLOAD_BITS_DEF;
   localparam logic [srr_pkg::PAYLOAD_W-1:0] PAYLOAD_MASK =
      {srr_pkg::PAYLOAD_W{1'b1}} >> (64 - PAYLOAD_BITS);

   localparam int RESET_CYCLES  = 12;
   localparam int PHASE_ITEMS   = 78;
   localparam int PRESSURE_ITEMS = 60;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 20;
   localparam int NUM_ROWS       = 20;

   // how a stimulus row is checked
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_DROP,
      ROW_ACK_ONLY
   } row_mode_type;

   typedef struct packed {
      logic                          checksum_ok;
      logic [srr_pkg::SEQ_W-1:0]     seq_number;
      logic [srr_pkg::PAYLOAD_W-1:0] payload_word;
   } packet_type;

   typedef struct packed {
      logic                          result_kind;
      logic [srr_pkg::SEQ_W-1:0]     ack_number;
      logic [srr_pkg::PAYLOAD_W-1:0] delivered_payload;
      logic                          last_of_run;
   } result_type;

   typedef struct packed {
      row_mode_type mode;
      packet_type   pkt;
   } row_type;

   // directed packets, starting from the reset window 0..3
   localparam row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      '{ROW_DROP,     '{1'b0, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF}},  // bad checksum
      '{ROW_ACK_ONLY, '{1'b1, 3'd4, 64'h0000_0000_0000_0000}},  // just past window
      '{ROW_ACK_ONLY, '{1'b1, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF}},  // far outside
      '{ROW_ACK_ONLY, '{1'b1, 3'd3, 64'hFFFF_FFFF_FFFF_FFFF}},  // top of window
      '{ROW_ACK_ONLY, '{1'b1, 3'd2, 64'h0000_0000_0000_0000}},
      '{ROW_ACK_ONLY, '{1'b1, 3'd2, 64'h5555_5555_5555_5555}},  // duplicate in window
      '{ROW_ACK_ONLY, '{1'b1, 3'd1, 64'hAAAA_AAAA_AAAA_AAAA}},
      '{ROW_PREDICT,  '{1'b1, 3'd0, 64'h0123_4567_89AB_CDEF}},  // releases four
      '{ROW_DROP,     '{1'b0, 3'd4, 64'h0000_0000_0000_0000}},
      '{ROW_ACK_ONLY, '{1'b1, 3'd0, 64'hDEAD_BEEF_0000_0001}},  // old, already delivered
      '{ROW_ACK_ONLY, '{1'b1, 3'd7, 64'h8000_0000_0000_0000}},
      '{ROW_PREDICT,  '{1'b1, 3'd4, 64'h0000_0000_0000_0001}},
      '{ROW_PREDICT,  '{1'b1, 3'd5, 64'hFEDC_BA98_7654_3210}},
      '{ROW_PREDICT,  '{1'b1, 3'd6, 64'h7FFF_FFFF_FFFF_FFFF}},  // wraps base to 0
      '{ROW_PREDICT,  '{1'b1, 3'd3, 64'h1111_2222_3333_4444}},
      '{ROW_PREDICT,  '{1'b1, 3'd0, 64'h0000_0000_0000_0000}},
      '{ROW_DROP,     '{1'b0, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF}},
      '{ROW_PREDICT,  '{1'b1, 3'd1, 64'hC3C3_C3C3_C3C3_C3C3}},
      '{ROW_PREDICT,  '{1'b1, 3'd2, 64'h3C3C_3C3C_3C3C_3C3C}},
      '{ROW_PREDICT,  '{1'b1, 3'd7, 64'h0F0F_0F0F_0F0F_0F0F}}
   };

   logic clock;
   logic reset;

   srr_req_if packet_ch ();
   srr_rsp_if result_ch ();

   selective_repeat_receiver u_top (
      .clock (clock),
      .reset (reset),
      .req   (packet_ch),
      .rsp   (result_ch)
   );

   // window model
   int unsigned                   win_base;
   logic                          slot_marked [WINDOW_SIZE];
   logic [srr_pkg::PAYLOAD_W-1:0] slot_word   [WINDOW_SIZE];
   result_type                    run_q [$];
   result_type                    pending_results [$];

   int sender_idle_pct;
   int sink_stall_pct;
   bit holdoff_request;
   int error_count;
   int quiet_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // compute the result items of one packet into run_q and advance the window
   function automatic void predict_packet(input packet_type p);
      int unsigned                   offset;
      result_type                    res;
      logic [srr_pkg::PAYLOAD_W-1:0] head_word;
      run_q.delete();
      if (p.checksum_ok) begin
         offset = ((int'(p.seq_number) % SEQ_SPACE) + SEQ_SPACE - win_base) % SEQ_SPACE;
         if (offset < WINDOW_SIZE && !slot_marked[offset]) begin
            slot_word[offset]   = p.payload_word & PAYLOAD_MASK;
            slot_marked[offset] = 1'b1;
         end
         res = '{srr_pkg::KIND_ACK, p.seq_number, '0, 1'b0};
         run_q.insert(run_q.size(), res);
         // release in-order slots from the head of the window
         while (slot_marked[0]) begin
            head_word = slot_word[0];
            for (int i = 0; i + 1 < WINDOW_SIZE; i++) begin
               slot_marked[i] = slot_marked[i + 1];
               slot_word[i]   = slot_word[i + 1];
            end
            slot_marked[WINDOW_SIZE - 1] = 1'b0;
            slot_word[WINDOW_SIZE - 1]   = head_word;
            win_base = (win_base + 1) % SEQ_SPACE;
            res = '{srr_pkg::KIND_DELIVER, '0, head_word, 1'b0};
            run_q.insert(run_q.size(), res);
         end
         run_q[run_q.size() - 1].last_of_run = 1'b1;
      end
   endfunction

   // queue the expected items of an accepted packet
   function automatic void record_packet(input packet_type p, input row_mode_type mode);
      result_type ack;
      predict_packet(p);
      unique case (mode)
         ROW_PREDICT: begin
            foreach (run_q[i]) pending_results.insert(pending_results.size(), run_q[i]);
         end
         ROW_ACK_ONLY: begin
            ack = '{srr_pkg::KIND_ACK, p.seq_number, '0, 1'b1};
            pending_results.insert(pending_results.size(), ack);
         end
         default: begin
         end
      endcase
   endfunction

   // mostly in-window packets, with some corrupted and some anywhere
   function automatic packet_type random_packet();
      packet_type  p;
      int unsigned pick;
      pick = $urandom_range(99);
      p.payload_word = {$urandom, $urandom};
      p.checksum_ok  = (pick >= 8);
      if (pick < 20)
         p.seq_number = srr_pkg::SEQ_W'($urandom_range(SEQ_SPACE - 1));
      else
         p.seq_number = srr_pkg::SEQ_W'((win_base + $urandom_range(WINDOW_SIZE - 1))
                                        % SEQ_SPACE);
      return p;
   endfunction

   // offer one packet; entered and left at a falling edge
   task automatic offer_packet(input packet_type p, input row_mode_type mode);
      if ($urandom_range(99) < sender_idle_pct) begin
         packet_ch.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      packet_ch.valid        <= 1'b1;
      packet_ch.checksum_ok  <= p.checksum_ok;
      packet_ch.seq_number   <= p.seq_number;
      packet_ch.payload_word <= p.payload_word;
      do @(posedge clock); while (!packet_ch.ready);
      record_packet(p, mode);
      @(negedge clock);
   endtask

   // hold the sender idle until every expected item has arrived
   task automatic drain_results();
      packet_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   // run random packets until the given number of good ones went in
   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
      packet_type p;
      int         good;
      sender_idle_pct = idle_pct;
      sink_stall_pct  = stall_pct;
      good = 0;
      while (good < count) begin
         p = random_packet();
         offer_packet(p, ROW_PREDICT);
         if (p.checksum_ok) good++;
      end
      drain_results();
   endtask

   // result side ready, with random stalls and one long hold-off on request
   initial begin
      int holdoff_left;
      bit holdoff_taken;
      holdoff_left    = 0;
      holdoff_taken   = 1'b0;
      result_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_request && !holdoff_taken) begin
            holdoff_left  = HOLDOFF_CYCLES;
            holdoff_taken = 1'b1;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            result_ch.ready <= 1'b0;
         end else begin
            result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // check each result item against the oldest expectation
   initial begin
      result_type got;
      result_type want;
      error_count = 0;
      forever begin
         @(posedge clock);
         if (!reset && result_ch.valid && result_ch.ready) begin
            got = '{result_ch.result_kind, result_ch.ack_number,
                    result_ch.delivered_payload, result_ch.last_of_run};
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result item: kind %0d ack %0d data %h last %0d",
                        $time, got.result_kind, got.ack_number, got.delivered_payload,
                        got.last_of_run);
            end else begin
               want = pending_results.pop_front();
               if (got.result_kind !== want.result_kind) begin
                  error_count++;
                  $display("%0t: result_kind expected %0d actual %0d",
                           $time, want.result_kind, got.result_kind);
               end
               if (got.ack_number !== want.ack_number) begin
                  error_count++;
                  $display("%0t: ack_number expected %0d actual %0d",
                           $time, want.ack_number, got.ack_number);
               end
               if (got.delivered_payload !== want.delivered_payload) begin
                  error_count++;
                  $display("%0t: delivered_payload expected %h actual %h",
                           $time, want.delivered_payload, got.delivered_payload);
               end
               if (got.last_of_run !== want.last_of_run) begin
                  error_count++;
                  $display("%0t: last_of_run expected %0d actual %0d",
                           $time, want.last_of_run, got.last_of_run);
               end
            end
         end
      end
   end

   // end the run when neither channel moves an item for too long
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (packet_ch.valid && packet_ch.ready) ||
             (result_ch.valid && result_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // main sequence
   initial begin
      reset                  = 1'b1;
      packet_ch.valid        = 1'b0;
      packet_ch.checksum_ok  = 1'b0;
      packet_ch.seq_number   = '0;
      packet_ch.payload_word = '0;
      sender_idle_pct        = 0;
      sink_stall_pct         = 0;
      holdoff_request        = 1'b0;
      win_base               = 0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         slot_marked[i] = 1'b0;
         slot_word[i]   = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the stimulus table
      for (int r = 0; r < NUM_ROWS; r++)
         offer_packet(DIRECTED_ROWS[r].pkt, DIRECTED_ROWS[r].mode);
      drain_results();

      // random phases: no idling, sender idle, receiver stalling, both
      run_random_phase(0, 0, PHASE_ITEMS);
      run_random_phase(88, 0, PHASE_ITEMS);
      run_random_phase(0, 88, PHASE_ITEMS);
      run_random_phase(18, 18, PHASE_ITEMS);

      // hold off the receiver while the sender keeps offering
      holdoff_request = 1'b1;
      run_random_phase(0, 18, PRESSURE_ITEMS);

      // let the last run settle and catch any stray item
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
